// File: rtl/core/efc_pkg.sv
// Shared types, codes and constants for the element face corner index generator.
package efc_pkg;

  localparam int MAX_NODES_DEF = 128;
  // Widest local corner index: p*(p+1)^2 + (p+1)^2 - 1 for p = 15 is 4095.
  localparam int IDX_W = 12;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_LOCAL  = 2'd1,
    REQ_GLOBAL = 2'd2,
    REQ_RSVD   = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    EL_TRI     = 3'd0,
    EL_QUAD    = 3'd1,
    EL_TETRA   = 3'd2,
    EL_PYRAMID = 3'd3,
    EL_PRISM   = 3'd4,
    EL_HEX     = 3'd5
  } elem_kind_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [6:0]  node_slot;
    logic [31:0] node_id;
    logic [2:0]  element_type;
    logic [3:0]  poly_degree;
    logic [7:0]  dof_count;
  } req_t;

  typedef struct packed {
    logic [2:0]  face_index;
    logic [2:0]  face_count;
    logic [2:0]  point_count;
    logic [31:0] corner_a;
    logic [31:0] corner_b;
    logic [31:0] corner_c;
    logic [31:0] corner_d;
    logic        last_face;
  } rsp_t;

  typedef struct packed {
    logic [2:0]       np;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
    logic [IDX_W-1:0] d;
  } face_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP_A,
    ST_SETUP_B,
    ST_READ,
    ST_READ_END,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_query;
    logic mem_wr;
    logic setup_a;
    logic setup_b;
    logic rd_en;
    logic emit;
    logic face_next;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic global_mode;
    logic rd_last;
    logic out_free;
    logic last_face;
  } status_t;

endpackage

// File: rtl/core/element_face_corner_index_gen_top.sv
// Top level of the element face corner index generator.
//
//   channel | dir | payload | handshake
//   req     | in  | req_t   | req_valid / req_ready
//   rsp     | out | rsp_t   | rsp_valid / rsp_ready
//
// A load request writes the table and leaves the block idle. A local query runs set-up
// in ST_SETUP_A and ST_SETUP_B, then emits one face per cycle while results are not stalled;
// a global query reads the corners of each face through the single node table read port.
// Reset clears the controller and the result valid; the table is not cleared.
// A stalled result holds the emit step; requests are taken only when idle.
module element_face_corner_index_gen_top
  import efc_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
)
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp_data
);

  cmd_t    cmd;
  status_t status;

  efc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req_data.req_type),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  efc_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

endmodule

// File: rtl/core/efc_ctrl.sv
// Controller state machine that sequences set-up, table reads and result emission.
module efc_ctrl
  import efc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  logic [1:0] req_type,
  output logic      req_ready,
  input  status_t   status,
  output cmd_t      cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid && (req_type == REQ_LOCAL || req_type == REQ_GLOBAL)) begin
          state_next = ST_SETUP_A;
        end
      end
      ST_SETUP_A: state_next = ST_SETUP_B;
      ST_SETUP_B: state_next = status.global_mode ? ST_READ : ST_EMIT;
      ST_READ: begin
        if (status.rd_last) begin
          state_next = ST_READ_END;
        end
      end
      ST_READ_END: state_next = ST_EMIT;
      ST_EMIT: begin
        if (status.out_free) begin
          if (status.last_face) begin
            state_next = ST_IDLE;
          end else begin
            state_next = status.global_mode ? ST_READ : ST_EMIT;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.mem_wr     = (req_type == REQ_LOAD);
          cmd.load_query = (req_type == REQ_LOCAL || req_type == REQ_GLOBAL);
        end
      end
      ST_SETUP_A:  cmd.setup_a = 1'b1;
      ST_SETUP_B:  cmd.setup_b = 1'b1;
      ST_READ:     cmd.rd_en   = 1'b1;
      ST_READ_END: cmd         = '0;
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.face_next = !status.last_face;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

// File: rtl/core/efc_dp.sv
// Datapath: node table memory, corner formulas, read pipeline and result register.
module efc_dp
  import efc_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
)
(
  input  logic    clk,
  input  logic    rst,
  input  req_t    req_data,
  input  cmd_t    cmd,
  output status_t status,
  output logic    rsp_valid,
  input  logic    rsp_ready,
  output rsp_t    rsp_data
);

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  logic [31:0] mem [MAX_NODES];

  logic             global_mode;
  logic [2:0]       type_r;
  logic [3:0]       p_r;
  logic [7:0]       last_r;
  logic [7:0]       tri_r;
  logic [8:0]       sq_r;
  logic [7:0]       pq_r;
  logic [IDX_W-1:0] h_r;
  logic [2:0]       face_k;
  logic [1:0]       rd_j;
  logic             rd_pend;
  logic [1:0]       rd_jq;
  logic             rd_selq;
  logic [31:0]      mem_q;
  logic [31:0]      cap [4];

  logic [4:0]       pp1;
  logic [4:0]       pp2;
  logic [9:0]       prod12;
  logic [IDX_W-1:0] p12, l12, q12, h12, t1, s1, bq;
  face_t            face;
  logic [2:0]       nf;
  logic [IDX_W-1:0] corner_sel;
  logic             rd_sel;
  logic [IDX_W-1:0] fc [4];

  function automatic face_t put(input logic [2:0] cnt, input logic [IDX_W-1:0] a,
                                input logic [IDX_W-1:0] b, input logic [IDX_W-1:0] c,
                                input logic [IDX_W-1:0] d);
    face_t f;
    f.np = cnt;
    f.a  = a;
    f.b  = b;
    f.c  = c;
    f.d  = d;
    return f;
  endfunction

  assign pp1    = 5'(p_r) + 5'd1;
  assign pp2    = 5'(p_r) + 5'd2;
  assign prod12 = 10'(pp1 * pp2);

  // Per-type base values: t1 is the last node of the triangular layer,
  // s1 the last node of the square layer, bq the first node of its top row.
  assign p12 = IDX_W'(p_r);
  assign l12 = IDX_W'(last_r);
  assign q12 = IDX_W'(pq_r);
  assign h12 = h_r;
  assign t1  = IDX_W'(tri_r) - IDX_W'(1);
  assign s1  = IDX_W'(sq_r) - IDX_W'(1);
  assign bq  = s1 - p12;

  always_comb begin
    face = '0;
    nf   = 3'd0;
    case (type_r)
      EL_TRI: begin
        nf = 3'd3;
        case (face_k)
          3'd0: face = put(3'd2, '0, p12, '0, '0);
          3'd1: face = put(3'd2, p12, l12, '0, '0);
          3'd2: face = put(3'd2, l12, '0, '0, '0);
          default: face = '0;
        endcase
      end
      EL_QUAD: begin
        nf = 3'd4;
        case (face_k)
          3'd0: face = put(3'd2, '0, p12, '0, '0);
          3'd1: face = put(3'd2, p12, l12, '0, '0);
          3'd2: face = put(3'd2, l12, q12, '0, '0);
          3'd3: face = put(3'd2, q12, '0, '0, '0);
          default: face = '0;
        endcase
      end
      EL_TETRA: begin
        nf = 3'd4;
        case (face_k)
          3'd0: face = put(3'd3, '0, p12, t1, '0);
          3'd1: face = put(3'd3, '0, l12, p12, '0);
          3'd2: face = put(3'd3, '0, t1, l12, '0);
          3'd3: face = put(3'd3, p12, l12, t1, '0);
          default: face = '0;
        endcase
      end
      EL_PYRAMID: begin
        nf = 3'd5;
        case (face_k)
          3'd0: face = put(3'd4, '0, p12, s1, bq);
          3'd1: face = put(3'd3, '0, l12, p12, '0);
          3'd2: face = put(3'd3, bq, s1, l12, '0);
          3'd3: face = put(3'd3, '0, bq, l12, '0);
          3'd4: face = put(3'd3, p12, l12, s1, '0);
          default: face = '0;
        endcase
      end
      EL_PRISM: begin
        nf = 3'd5;
        case (face_k)
          3'd0: face = put(3'd3, '0, p12, t1, '0);
          3'd1: face = put(3'd3, h12, t1 + h12, p12 + h12, '0);
          3'd2: face = put(3'd4, '0, h12, p12 + h12, p12);
          3'd3: face = put(3'd4, '0, t1, t1 + h12, h12);
          3'd4: face = put(3'd4, p12, p12 + h12, t1 + h12, t1);
          default: face = '0;
        endcase
      end
      EL_HEX: begin
        nf = 3'd6;
        case (face_k)
          3'd0: face = put(3'd4, '0, p12, s1, bq);
          3'd1: face = put(3'd4, h12, bq + h12, s1 + h12, p12 + h12);
          3'd2: face = put(3'd4, '0, h12, p12 + h12, p12);
          3'd3: face = put(3'd4, bq, s1, s1 + h12, bq + h12);
          3'd4: face = put(3'd4, '0, bq, bq + h12, h12);
          3'd5: face = put(3'd4, p12, p12 + h12, s1 + h12, s1);
          default: face = '0;
        endcase
      end
      default: begin
        face = '0;
        nf   = 3'd0;
      end
    endcase
  end

  assign fc[0] = face.a;
  assign fc[1] = face.b;
  assign fc[2] = face.c;
  assign fc[3] = face.d;

  assign corner_sel = fc[rd_j];
  // Unused corners and indices past the table end report zero.
  assign rd_sel = ({1'b0, rd_j} < face.np) && (32'(corner_sel) < 32'(MAX_NODES));

  assign status.global_mode = global_mode;
  assign status.rd_last     = (rd_j == 2'd3);
  assign status.out_free    = !rsp_valid || rsp_ready;
  assign status.last_face   = (nf == 3'd0) || (3'(face_k + 3'd1) == nf);

  always_ff @(posedge clk) begin
    if (cmd.mem_wr && (32'(req_data.node_slot) < 32'(MAX_NODES))) begin
      mem[AW'(req_data.node_slot)] <= req_data.node_id;
    end
    if (cmd.rd_en) begin
      mem_q <= mem[AW'(corner_sel)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      global_mode <= (req_data.req_type == REQ_GLOBAL);
      type_r      <= req_data.element_type;
      p_r         <= req_data.poly_degree;
      last_r      <= (req_data.dof_count == 8'd0) ? 8'd0 : req_data.dof_count - 8'd1;
    end
    if (cmd.setup_a) begin
      tri_r <= 8'(prod12 >> 1);
      sq_r  <= 9'(pp1 * pp1);
      pq_r  <= 8'(p_r * pp1);
    end
    if (cmd.setup_b) begin
      h_r <= IDX_W'(p_r * ((type_r == EL_PRISM) ? 9'(tri_r) : sq_r));
    end
    rd_jq   <= rd_j;
    rd_selq <= rd_sel;
    if (rd_pend) begin
      cap[rd_jq] <= rd_selq ? mem_q : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      face_k    <= 3'd0;
      rd_j      <= 2'd0;
      rd_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rd_pend <= cmd.rd_en;
      if (cmd.load_query) begin
        face_k <= 3'd0;
        rd_j   <= 2'd0;
      end else begin
        if (cmd.face_next) begin
          face_k <= face_k + 3'd1;
        end
        if (cmd.face_next) begin
          rd_j <= 2'd0;
        end else if (cmd.rd_en) begin
          rd_j <= rd_j + 2'd1;
        end
      end
      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp_data.face_index  <= face_k;
      rsp_data.face_count  <= nf;
      rsp_data.point_count <= face.np;
      rsp_data.last_face   <= status.last_face;
      if (global_mode) begin
        rsp_data.corner_a <= cap[0];
        rsp_data.corner_b <= cap[1];
        rsp_data.corner_c <= cap[2];
        rsp_data.corner_d <= cap[3];
      end else begin
        rsp_data.corner_a <= 32'(face.a);
        rsp_data.corner_b <= 32'(face.b);
        rsp_data.corner_c <= 32'(face.c);
        rsp_data.corner_d <= 32'(face.d);
      end
    end
  end

endmodule

// File: rtl/core/efc_checker.sv
// Port-level checker for the element face corner index generator, with its bind.
module efc_checker
  import efc_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req_data,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp_data
);

  // A stalled result must hold.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result changed while stalled");

  // A query keeps the block busy through its set-up.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready &&
    (req_data.req_type == REQ_LOCAL || req_data.req_type == REQ_GLOBAL) |=> !req_ready)
    else $error("request taken during query set-up");

  // A load request completes at once.
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_data.req_type == REQ_LOAD |=> req_ready)
    else $error("load request left the block busy");

  a_face_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_data.face_count == 3'd0 || rsp_data.face_index < rsp_data.face_count)
    else $error("face index beyond face count");

  // An unknown element type gives a single empty result.
  a_unknown: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.face_count == 3'd0 |->
    rsp_data.last_face && rsp_data.point_count == 3'd0 && rsp_data.corner_a == 32'd0)
    else $error("malformed result for unknown element type");

endmodule

bind element_face_corner_index_gen_top efc_checker u_efc_checker (.*);

// File: dv/efc_face_checker.sv
// Checker for the element face corner index generator: predicts and compares face results.
`timescale 1ns / 1ps
module efc_face_checker
  import efc_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
)
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req_data,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp_data,
  output int   fail_count,
  output int   pending
);

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  logic [31:0] node_mem [MAX_NODES];
  rsp_t        face_q [$];
  rsp_t        want;
  bit          ok;

  function automatic bit field_ok(string name, logic [31:0] exp_val, logic [31:0] got_val);
    if (exp_val !== got_val) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, got_val);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Works out the faces of one query and queues one expected result per face.
  task automatic predict_faces(input req_t r);
    logic [31:0] p, n, last, s, h, b, li;
    logic [31:0] crn [6][4];
    logic [2:0]  npt [6];
    int          nf, k, j;
    rsp_t        e;
    p = 32'(r.poly_degree);
    n = 32'(r.dof_count);
    last = (n == 0) ? 32'd0 : n - 32'd1;
    nf = 0;
    for (k = 0; k < 6; k++) begin
      npt[k] = 3'd0;
      for (j = 0; j < 4; j++) crn[k][j] = '0;
    end
    case (r.element_type)
      EL_TRI: begin
        crn[0] = '{32'd0, p, 32'd0, 32'd0};    npt[0] = 3'd2;
        crn[1] = '{p, last, 32'd0, 32'd0};     npt[1] = 3'd2;
        crn[2] = '{last, 32'd0, 32'd0, 32'd0}; npt[2] = 3'd2;
        nf = 3;
      end
      EL_QUAD: begin
        s = p * (p + 1);
        crn[0] = '{32'd0, p, 32'd0, 32'd0};   npt[0] = 3'd2;
        crn[1] = '{p, last, 32'd0, 32'd0};    npt[1] = 3'd2;
        crn[2] = '{last, s, 32'd0, 32'd0};    npt[2] = 3'd2;
        crn[3] = '{s, 32'd0, 32'd0, 32'd0};   npt[3] = 3'd2;
        nf = 4;
      end
      EL_TETRA: begin
        s = (p + 1) * (p + 2) / 2 - 1;
        crn[0] = '{32'd0, p, s, 32'd0};    npt[0] = 3'd3;
        crn[1] = '{32'd0, last, p, 32'd0}; npt[1] = 3'd3;
        crn[2] = '{32'd0, s, last, 32'd0}; npt[2] = 3'd3;
        crn[3] = '{p, last, s, 32'd0};     npt[3] = 3'd3;
        nf = 4;
      end
      EL_PYRAMID: begin
        s = (p + 1) * (p + 1) - 1;
        b = s - p;
        crn[0] = '{32'd0, p, s, b};        npt[0] = 3'd4;
        crn[1] = '{32'd0, last, p, 32'd0}; npt[1] = 3'd3;
        crn[2] = '{b, s, last, 32'd0};     npt[2] = 3'd3;
        crn[3] = '{32'd0, b, last, 32'd0}; npt[3] = 3'd3;
        crn[4] = '{p, last, s, 32'd0};     npt[4] = 3'd3;
        nf = 5;
      end
      EL_PRISM: begin
        s = (p + 1) * (p + 2) / 2;
        h = p * s;
        s = s - 1;
        crn[0] = '{32'd0, p, s, 32'd0};         npt[0] = 3'd3;
        crn[1] = '{h, s + h, p + h, 32'd0};     npt[1] = 3'd3;
        crn[2] = '{32'd0, h, p + h, p};         npt[2] = 3'd4;
        crn[3] = '{32'd0, s, s + h, h};         npt[3] = 3'd4;
        crn[4] = '{p, p + h, s + h, s};         npt[4] = 3'd4;
        nf = 5;
      end
      EL_HEX: begin
        s = (p + 1) * (p + 1);
        h = p * s;
        s = s - 1;
        b = s - p;
        crn[0] = '{32'd0, p, s, b};             npt[0] = 3'd4;
        crn[1] = '{h, b + h, s + h, p + h};     npt[1] = 3'd4;
        crn[2] = '{32'd0, h, p + h, p};         npt[2] = 3'd4;
        crn[3] = '{b, s, s + h, b + h};         npt[3] = 3'd4;
        crn[4] = '{32'd0, b, b + h, h};         npt[4] = 3'd4;
        crn[5] = '{p, p + h, s + h, s};         npt[5] = 3'd4;
        nf = 6;
      end
      default: nf = 0;
    endcase

    if (nf == 0) begin
      e = '0;
      e.last_face = 1'b1;
      face_q.push_back(e);
    end else begin
      for (k = 0; k < nf; k++) begin
        // In global mode each used corner becomes the stored id, or zero past the table.
        if (r.req_type == REQ_GLOBAL) begin
          for (j = 0; j < npt[k]; j++) begin
            li = crn[k][j];
            crn[k][j] = (li < MAX_NODES) ? node_mem[li[AW-1:0]] : 32'd0;
          end
        end
        e.face_index  = 3'(k);
        e.face_count  = 3'(nf);
        e.point_count = npt[k];
        e.corner_a    = crn[k][0];
        e.corner_b    = crn[k][1];
        e.corner_c    = crn[k][2];
        e.corner_d    = crn[k][3];
        e.last_face   = (k == nf - 1);
        face_q.push_back(e);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fail_count = 0;
      pending = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (face_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, rsp_data);
          fail_count++;
        end else begin
          want = face_q.pop_front();
          ok = field_ok("face_index", 32'(want.face_index), 32'(rsp_data.face_index))
             & field_ok("face_count", 32'(want.face_count), 32'(rsp_data.face_count))
             & field_ok("point_count", 32'(want.point_count), 32'(rsp_data.point_count))
             & field_ok("corner_a", want.corner_a, rsp_data.corner_a)
             & field_ok("corner_b", want.corner_b, rsp_data.corner_b)
             & field_ok("corner_c", want.corner_c, rsp_data.corner_c)
             & field_ok("corner_d", want.corner_d, rsp_data.corner_d)
             & field_ok("last_face", 32'(want.last_face), 32'(rsp_data.last_face));
          if (!ok) fail_count++;
        end
      end
      if (req_valid && req_ready) begin
        if (req_data.req_type == REQ_LOAD) begin
          if (req_data.node_slot < MAX_NODES) begin
            node_mem[AW'(req_data.node_slot)] = req_data.node_id;
          end
        end else if (req_data.req_type != REQ_RSVD) begin
          predict_faces(req_data);
        end
      end
      pending = face_q.size();
    end
  end

endmodule

// File: dv/element_face_corner_index_gen_top_tb.sv
// Testbench top for the element face corner index generator: stimulus and verdict.
`timescale 1ns / 1ps
module element_face_corner_index_gen_top_tb;
  import efc_pkg::*;

  // Element type codes that the block does not know.
  localparam logic [2:0] EL_UNKNOWN_LO = 3'd6;
  localparam logic [2:0] EL_UNKNOWN_HI = 3'd7;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req_data;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp_data;
  int   fail_count;
  int   pending;
  bit   quiet;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  element_face_corner_index_gen_top #(.MAX_NODES(MAX_NODES_DEF)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  efc_face_checker #(.MAX_NODES(MAX_NODES_DEF)) checker_i (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req_data   (req_data),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp_data   (rsp_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Mostly short gaps, now and then a long one; none at all while quiet is set.
  function automatic int pick_gap();
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic req_t make_req(req_kind_t kind, logic [2:0] et, logic [3:0] p,
                                    logic [7:0] n);
    req_t r;
    r.req_type     = kind;
    r.node_slot    = 7'($urandom);
    r.node_id      = $urandom;
    r.element_type = et;
    r.poly_degree  = p;
    r.dof_count    = n;
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_req(input req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  task automatic load_slot(input logic [6:0] slot, input logic [31:0] id);
    req_t r;
    r = make_req(REQ_LOAD, 3'($urandom), 4'($urandom), 8'($urandom));
    r.node_slot = slot;
    r.node_id   = id;
    send_req(r);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Result side: random stalls between bursts of readiness.
  initial begin
    int gap;
    rsp_ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  initial begin
    #8_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    req_t r;
    int   pick;
    rst       = 1'b1;
    req_valid = 1'b0;
    req_data  = '0;
    quiet     = 1'b0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Local queries need no table contents, so every type goes first.
    send_req(make_req(REQ_LOCAL, EL_TRI, 4'd1, 8'd3));
    send_req(make_req(REQ_LOCAL, EL_QUAD, 4'd15, 8'd255));
    send_req(make_req(REQ_LOCAL, EL_TETRA, 4'd0, 8'd0));
    send_req(make_req(REQ_LOCAL, EL_PYRAMID, 4'd2, 8'd14));
    send_req(make_req(REQ_LOCAL, EL_PRISM, 4'd15, 8'd128));
    send_req(make_req(REQ_LOCAL, EL_HEX, 4'd1, 8'd8));
    send_req(make_req(REQ_LOCAL, EL_UNKNOWN_LO, 4'd3, 8'd10));
    send_req(make_req(REQ_LOCAL, EL_UNKNOWN_HI, 4'd15, 8'd255));
    send_req(make_req(REQ_RSVD, EL_HEX, 4'd2, 8'd27));
    load_slot(7'd0, 32'd0);
    load_slot(7'd127, 32'hFFFF_FFFF);

    // Fill the whole table so that no global query ever reads an unwritten slot.
    for (int slot = 0; slot < MAX_NODES_DEF; slot++) begin
      if (slot == 0)        load_slot(7'(slot), 32'd0);
      else if (slot == 127) load_slot(7'(slot), 32'hFFFF_FFFF);
      else                  load_slot(7'(slot), $urandom);
    end

    send_req(make_req(REQ_GLOBAL, EL_TRI, 4'd1, 8'd3));
    send_req(make_req(REQ_GLOBAL, EL_TRI, 4'd1, 8'd200));
    send_req(make_req(REQ_GLOBAL, EL_QUAD, 4'd2, 8'd9));
    send_req(make_req(REQ_GLOBAL, EL_TETRA, 4'd3, 8'd20));
    send_req(make_req(REQ_GLOBAL, EL_PYRAMID, 4'd1, 8'd5));
    send_req(make_req(REQ_GLOBAL, EL_PRISM, 4'd1, 8'd6));
    send_req(make_req(REQ_GLOBAL, EL_HEX, 4'd15, 8'd255));
    send_req(make_req(REQ_GLOBAL, EL_UNKNOWN_HI, 4'd0, 8'd0));
    wait_drained();

    for (int i = 0; i < 120; i++) begin
      quiet = (i >= 40 && i < 70);
      if (i % 30 == 29) wait_drained();
      pick = $urandom_range(0, 99);
      r = make_req(REQ_LOCAL, 3'($urandom_range(0, 5)), 4'($urandom_range(0, 15)),
                   8'($urandom));
      if (pick < 20)      r.req_type = REQ_LOAD;
      else if (pick < 25) r.req_type = REQ_RSVD;
      else if (pick < 62) r.req_type = REQ_GLOBAL;
      if ($urandom_range(0, 9) == 0) r.element_type = 3'($urandom_range(6, 7));
      send_req(r);
    end
    quiet = 1'b0;

    wait_drained();
    repeat (60) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
